// File: rtl/core/weighted_priority_aging_scheduler_unit_defines.svh
// ----------------------------------------------------------------------------
// Weighted priority aging scheduler assertion macros
// Shared concurrent-assertion wrappers, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_PRIORITY_AGING_SCHEDULER_UNIT_DEFINES_SVH
`define WEIGHTED_PRIORITY_AGING_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication
`define WPAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WPAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/wpas_pkg.sv
// ----------------------------------------------------------------------------
// Weighted priority aging scheduler package
// Widths, register indexes, reset values, shared types and the lane score.
// ----------------------------------------------------------------------------
package wpas_pkg;

    // Lane storage
    localparam int NUM_LANES    = 4;
    localparam int LANE_IDX_W   = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

    // Field widths
    localparam int LANE_FIELD_W = 4;
    localparam int VEH_W        = 10;
    localparam int WAIT_W       = 12;
    localparam int WIDTH_W      = 4;
    localparam int SCORE_W      = 14;
    localparam int BOOST_W      = 8;
    localparam int DISCH_W      = 8;
    localparam int STEP_W       = 8;

    // Stream widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 48;

    // Configuration port
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_AGING_THRESHOLD  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AGING_BOOST      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISCHARGE_AMOUNT = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_STEP        = 8'd3;

    localparam logic [WAIT_W-1:0]  RST_AGING_THRESHOLD  = 12'd30;
    localparam logic [BOOST_W-1:0] RST_AGING_BOOST      = 8'd20;
    localparam logic [DISCH_W-1:0] RST_DISCHARGE_AMOUNT = 8'd5;
    localparam logic [STEP_W-1:0]  RST_WAIT_STEP        = 8'd10;

    localparam logic [WAIT_W-1:0]  WAIT_MAX = '1;

    // Schedule item action codes
    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_SCHEDULE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic                  load_en;
        logic                  scan_en;
        logic                  scan_first;
        logic                  upd_en;
        logic                  push;
        logic [LANE_IDX_W-1:0] idx;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // Score: 2*count + 3*wait + width, plus boost once the wait passes threshold
    function automatic logic [SCORE_W-1:0] lane_score(
        input logic [VEH_W-1:0]   veh,
        input logic [WAIT_W-1:0]  wt,
        input logic [WIDTH_W-1:0] wd,
        input logic [WAIT_W-1:0]  thr,
        input logic [BOOST_W-1:0] boost
    );
        logic [SCORE_W-1:0] s;
        s = SCORE_W'({veh, 1'b0}) + SCORE_W'({wt, 1'b0}) + SCORE_W'(wt) + SCORE_W'(wd);
        if (wt > thr) begin
            s = s + SCORE_W'(boost);
        end
        return s;
    endfunction

endpackage

// File: rtl/core/wpas_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences accept, lane scan, lane update and result hand-off.
// ----------------------------------------------------------------------------
`include "weighted_priority_aging_scheduler_unit_defines.svh"

module wpas_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_action,
    output logic                  s_tready,
    input  wpas_pkg::dp_stat_t    stat,
    output wpas_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_PUSH   = 2'd3;

    localparam logic [wpas_pkg::LANE_IDX_W-1:0] LAST_LANE =
        wpas_pkg::LANE_IDX_W'(wpas_pkg::NUM_LANES - 1);

    logic [1:0]                      state_reg, state_next;
    logic [wpas_pkg::LANE_IDX_W-1:0] cnt_reg, cnt_next;
    logic                            s_beat;
    logic                            last_lane;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_beat    = s_tvalid && s_tready;
    assign last_lane = (cnt_reg == LAST_LANE);

    // Next state and lane counter
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_beat && (s_action == wpas_pkg::ACT_SCHEDULE)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_lane) begin
                    state_next = ST_UPDATE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPDATE: begin
                if (last_lane) begin
                    state_next = ST_PUSH;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PUSH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Commands to the datapath
    always_comb begin
        cmd.load_en    = s_beat && (s_action == wpas_pkg::ACT_LOAD);
        cmd.scan_en    = (state_reg == ST_SCAN);
        cmd.scan_first = (state_reg == ST_SCAN) && (cnt_reg == '0);
        cmd.upd_en     = (state_reg == ST_UPDATE);
        cmd.push       = (state_reg == ST_PUSH) && stat.out_free;
        cmd.idx        = cnt_reg;
    end

    `WPAS_ASSERT_NOW(a_push_needs_slot, cmd.push, stat.out_free, "push into a full output slot")
    `WPAS_ASSERT_NEXT(a_push_then_ready, cmd.push, s_tready, "not ready after a push")
    `WPAS_ASSERT_NEXT(a_scan_to_update, (state_reg == ST_SCAN) && last_lane,
        cmd.upd_en && (cmd.idx == '0), "update did not follow the last scanned lane")

endmodule

// File: rtl/core/wpas_dp.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Lane registers, configuration registers, score compare and result register.
// ----------------------------------------------------------------------------
`include "weighted_priority_aging_scheduler_unit_defines.svh"

module wpas_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [wpas_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wpas_pkg::CFG_DATA_W-1:0]       cfg_data,
    // load fields
    input  logic [wpas_pkg::LANE_FIELD_W-1:0]     in_lane_index,
    input  logic [wpas_pkg::VEH_W-1:0]            in_vehicle_count,
    input  logic [wpas_pkg::WAIT_W-1:0]           in_waiting_time,
    input  logic [wpas_pkg::WIDTH_W-1:0]          in_road_width,
    // control
    input  wpas_pkg::ctrl_cmd_t                   cmd,
    output wpas_pkg::dp_stat_t                    stat,
    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [wpas_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int PAD_W = wpas_pkg::M_TDATA_W - wpas_pkg::LANE_FIELD_W - wpas_pkg::VEH_W
                         - wpas_pkg::WAIT_W - wpas_pkg::WIDTH_W - wpas_pkg::SCORE_W;

    localparam logic [wpas_pkg::LANE_FIELD_W:0] LANE_LIMIT =
        (wpas_pkg::LANE_FIELD_W + 1)'(wpas_pkg::NUM_LANES);

    // Configuration registers
    logic [wpas_pkg::WAIT_W-1:0]  thr_reg;
    logic [wpas_pkg::BOOST_W-1:0] boost_reg;
    logic [wpas_pkg::DISCH_W-1:0] disch_reg;
    logic [wpas_pkg::STEP_W-1:0]  step_reg;

    // Lane state
    logic [wpas_pkg::VEH_W-1:0]   veh_reg   [wpas_pkg::NUM_LANES];
    logic [wpas_pkg::WAIT_W-1:0]  wait_reg  [wpas_pkg::NUM_LANES];
    logic [wpas_pkg::WIDTH_W-1:0] width_reg [wpas_pkg::NUM_LANES];

    // Best lane so far
    logic [wpas_pkg::LANE_IDX_W-1:0] best_idx_reg;
    logic [wpas_pkg::SCORE_W-1:0]    best_score_reg;
    logic [wpas_pkg::VEH_W-1:0]      best_veh_reg;
    logic [wpas_pkg::WAIT_W-1:0]     best_wait_reg;
    logic [wpas_pkg::WIDTH_W-1:0]    best_width_reg;

    // Output slot
    logic                         m_valid_reg;
    logic [wpas_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [wpas_pkg::VEH_W-1:0]   cur_veh;
    logic [wpas_pkg::WAIT_W-1:0]  cur_wait;
    logic [wpas_pkg::WIDTH_W-1:0] cur_width;
    logic [wpas_pkg::SCORE_W-1:0] cur_score;
    logic [wpas_pkg::WAIT_W:0]    wait_sum;
    logic [wpas_pkg::WAIT_W-1:0]  wait_grown;
    logic [wpas_pkg::VEH_W-1:0]   veh_drained;
    logic                         load_hit;

    // Read the lane under the counter
    assign cur_veh   = veh_reg[cmd.idx];
    assign cur_wait  = wait_reg[cmd.idx];
    assign cur_width = width_reg[cmd.idx];
    assign cur_score = wpas_pkg::lane_score(cur_veh, cur_wait, cur_width, thr_reg, boost_reg);

    // Grow a waiting lane, saturating; drain the green lane, floored at zero
    assign wait_sum    = {1'b0, cur_wait} + (wpas_pkg::WAIT_W + 1)'(step_reg);
    assign wait_grown  = wait_sum[wpas_pkg::WAIT_W] ? wpas_pkg::WAIT_MAX
                                                    : wait_sum[wpas_pkg::WAIT_W-1:0];
    assign veh_drained = (cur_veh > wpas_pkg::VEH_W'(disch_reg))
                       ? cur_veh - wpas_pkg::VEH_W'(disch_reg) : '0;

    assign load_hit = cmd.load_en && ({1'b0, in_lane_index} < LANE_LIMIT);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= wpas_pkg::RST_AGING_THRESHOLD;
            boost_reg <= wpas_pkg::RST_AGING_BOOST;
            disch_reg <= wpas_pkg::RST_DISCHARGE_AMOUNT;
            step_reg  <= wpas_pkg::RST_WAIT_STEP;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wpas_pkg::CFG_AGING_THRESHOLD:  thr_reg   <= cfg_data;
                wpas_pkg::CFG_AGING_BOOST:      boost_reg <= cfg_data[wpas_pkg::BOOST_W-1:0];
                wpas_pkg::CFG_DISCHARGE_AMOUNT: disch_reg <= cfg_data[wpas_pkg::DISCH_W-1:0];
                wpas_pkg::CFG_WAIT_STEP:        step_reg  <= cfg_data[wpas_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Lane loads and per-lane updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < wpas_pkg::NUM_LANES; k++) begin
                veh_reg[k]   <= '0;
                wait_reg[k]  <= '0;
                width_reg[k] <= '0;
            end
        end else if (load_hit) begin
            veh_reg[in_lane_index[wpas_pkg::LANE_IDX_W-1:0]]   <= in_vehicle_count;
            wait_reg[in_lane_index[wpas_pkg::LANE_IDX_W-1:0]]  <= in_waiting_time;
            width_reg[in_lane_index[wpas_pkg::LANE_IDX_W-1:0]] <= in_road_width;
        end else if (cmd.upd_en) begin
            if (cmd.idx == best_idx_reg) begin
                veh_reg[cmd.idx]  <= veh_drained;
                wait_reg[cmd.idx] <= '0;
            end else begin
                wait_reg[cmd.idx] <= wait_grown;
            end
        end
    end

    // Track the best lane; strict compare keeps the lowest index on ties
    always_ff @(posedge aclk) begin
        if (cmd.scan_en && (cmd.scan_first || (cur_score > best_score_reg))) begin
            best_idx_reg   <= cmd.idx;
            best_score_reg <= cur_score;
            best_veh_reg   <= cur_veh;
            best_wait_reg  <= cur_wait;
            best_width_reg <= cur_width;
        end
    end

    // Output slot: load on push, drop once taken
    assign stat.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_data_reg <= {PAD_W'(0), best_score_reg, best_width_reg, best_wait_reg,
                           best_veh_reg, wpas_pkg::LANE_FIELD_W'(best_idx_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `WPAS_ASSERT_NEXT(a_best_monotonic, cmd.scan_en && !cmd.scan_first,
        best_score_reg >= $past(best_score_reg), "best score dropped during scan")
    `WPAS_ASSERT_NEXT(a_green_wait_cleared, cmd.upd_en && (cmd.idx == best_idx_reg),
        wait_reg[$past(cmd.idx)] == '0, "green lane wait not cleared")
    `WPAS_ASSERT_NOW(a_no_load_midrun, cmd.load_en, !cmd.scan_en && !cmd.upd_en,
        "load taken while a schedule runs")

endmodule

// File: rtl/core/weighted_priority_aging_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Weighted priority aging scheduler
// Picks a green lane by weighted score with an aging boost, then updates lanes.
// ----------------------------------------------------------------------------
// A load beat (tuser = 0) writes one lane's count, wait and width in the cycle it
// is accepted; a lane index past the last lane is dropped. A schedule beat
// (tuser = 1) is handled in steps from accept to the next ready: one lane is
// scored per cycle through a single scorer and compared against the best so
// far, then one lane per cycle is drained or aged
// through a single update unit, and the result goes into a one-entry output
// register. The input stays ready while that register waits to be taken; only
// the hand-off of a further result waits for it. Configuration writes are taken
// every cycle and must be issued while the block is idle.
module weighted_priority_aging_scheduler_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wpas_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wpas_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // lane_index[3:0], vehicle_count[13:4], waiting_time[25:14], road_width[29:26]
    input  logic [wpas_pkg::S_TDATA_W-1:0]      s_tdata,
    // action[0]
    input  logic                                s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // green_lane[3:0], green_vehicles[13:4], green_wait[25:14], green_width[29:26],
    // green_priority[43:30]
    output logic [wpas_pkg::M_TDATA_W-1:0]      m_tdata
);

    wpas_pkg::ctrl_cmd_t cmd;
    wpas_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    wpas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_action (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wpas_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_lane_index    (s_tdata[3:0]),
        .in_vehicle_count (s_tdata[13:4]),
        .in_waiting_time  (s_tdata[25:14]),
        .in_road_width    (s_tdata[29:26]),
        .cmd              (cmd),
        .stat             (stat),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule
